### rtl/nfpi_pkg.sv
// Shared types, constants and helpers for the Nova fractal pixel iterator.
// Used by every module in rtl; depends on nothing else.
package nfpi_pkg;

    localparam int Q_W    = 32;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;
    localparam int ACC_W  = 67;
    localparam int MAG_W  = 64;
    localparam int ITER_W = 13;

    localparam logic [1:0] STAT_ESCAPED    = 2'd0;
    localparam logic [1:0] STAT_CONVERGED  = 2'd1;
    localparam logic [1:0] STAT_UNRESOLVED = 2'd2;

    localparam logic [2:0] REG_JULIA    = 3'd0;
    localparam logic [2:0] REG_SEED_RE  = 3'd1;
    localparam logic [2:0] REG_SEED_IM  = 3'd2;
    localparam logic [2:0] REG_EXPONENT = 3'd3;
    localparam logic [2:0] REG_LIMIT    = 3'd4;
    localparam logic [2:0] REG_ESCAPE   = 3'd5;
    localparam logic [2:0] REG_RELAX    = 3'd6;
    localparam logic [2:0] REG_TOL      = 3'd7;

    typedef struct packed {
        logic signed [Q_W-1:0] pixel_real;
        logic signed [Q_W-1:0] pixel_imag;
    } pixel_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [ITER_W-1:0]     iterations;
        logic signed [Q_W-1:0] final_real;
        logic signed [Q_W-1:0] final_imag;
    } result_t;

    typedef struct packed {
        logic                  julia_select;
        logic signed [Q_W-1:0] seed_real;
        logic signed [Q_W-1:0] seed_imag;
        logic [Q_W-1:0]        escape_radius_sq;
        logic signed [Q_W-1:0] relax_factor;
        logic [Q_W-1:0]        tolerance_sq;
    } cfg_t;

    // Datapath micro-operations. M_ ops load the product register, A_ ops fold
    // the product into the accumulator, W_ ops write results back.
    typedef enum logic [5:0] {
        OP_NOP,
        OP_LOAD,
        OP_M_ZRZR, OP_M_ZIZI, OP_M_WRZR, OP_M_WIZI, OP_M_WRZI, OP_M_WIZR,
        OP_M_PWR, OP_M_PWI, OP_M_DRDR, OP_M_DIDI, OP_M_NRDR, OP_M_NIDI,
        OP_M_NIDR, OP_M_NRDI, OP_M_RQR, OP_M_RQI, OP_M_XDR, OP_M_XDI,
        OP_A_LDS, OP_A_ADDS, OP_A_SUBS, OP_A_LDR, OP_A_ADDR, OP_A_SUBR,
        OP_W_COPYZ, OP_W_TR, OP_W_TI, OP_W_T2W, OP_W_T2N, OP_W_DR, OP_W_DI,
        OP_W_DEN, OP_W_XR, OP_W_XI, OP_W_COMMIT,
        OP_DIV_START, OP_W_QR, OP_W_QI
    } op_t;

    typedef struct packed {
        logic esc;
        logic dz;
        logic conv;
        logic div_done;
    } dp_stat_t;

    typedef struct packed {
        op_t               op;
        logic              out_load;
        logic [1:0]        status;
        logic [ITER_W-1:0] iterations;
    } ctrl_cmd_t;

    localparam logic signed [ACC_W-1:0] QMAX_EXT = ACC_W'(32'sh7fffffff);
    localparam logic signed [ACC_W-1:0] QMIN_EXT = ACC_W'(32'sh80000000);

    // Saturates a wide signed value to the 32-bit fixed-point range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > QMAX_EXT) r = 32'sh7fffffff;
        else if (v < QMIN_EXT) r = 32'sh80000000;
        else r = v[Q_W-1:0];
        return r;
    endfunction

    // Clamps the configured power to the range the sequencer supports.
    function automatic logic [4:0] clamp_exponent(input logic [3:0] e, input logic [4:0] pmax);
        logic [4:0] v;
        v = {1'b0, e};
        if (v < 5'd2) v = 5'd2;
        if (v > pmax) v = pmax;
        return v;
    endfunction

endpackage

### rtl/nfpi_div.sv
// Restoring fixed-point divider, one quotient bit per cycle, with saturation.
// Depends on nfpi_pkg.
module nfpi_div #(
    parameter int FRACTION_BITS = 26
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            neg,
    input  logic [nfpi_pkg::MAG_W-1:0]      mag,
    input  logic [nfpi_pkg::MAG_W-1:0]      den,
    output logic                            done,
    output logic signed [nfpi_pkg::Q_W-1:0] q
);
    localparam int SH  = 31 - FRACTION_BITS;
    localparam int CW  = nfpi_pkg::MAG_W + SH;

    logic                       busy_reg;
    logic                       done_reg;
    logic                       neg_reg;
    logic [nfpi_pkg::MAG_W-1:0] mag_reg;
    logic [nfpi_pkg::MAG_W-1:0] den_reg;
    logic [nfpi_pkg::MAG_W-1:0] rem_reg;
    logic [30:0]                quo_reg;
    logic [4:0]                 bit_reg;
    logic signed [31:0]         q_reg;

    logic                       over;
    logic [5:0]                 idx;
    logic                       xb;
    logic [nfpi_pkg::MAG_W:0]   r2;
    logic                       ge;
    logic [nfpi_pkg::MAG_W:0]   rem_next;
    logic [30:0]                quo_next;
    logic signed [31:0]         qv;

    // The quotient cannot fit when mag >= den * 2^(31-F).
    assign over = (CW'(mag) >= (CW'(den) << SH));
    assign idx  = 6'(bit_reg) - 6'(FRACTION_BITS);
    assign xb   = (bit_reg >= 5'(FRACTION_BITS)) ? mag_reg[idx] : 1'b0;
    assign r2   = {rem_reg, xb};
    assign ge   = (r2 >= {1'b0, den_reg});

    always_comb
    begin
        rem_next = ge ? (r2 - {1'b0, den_reg}) : r2;
        quo_next = quo_reg;
        quo_next[bit_reg] = ge;
        qv = {1'b0, quo_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !over;
                done_reg <= over;
            end
            else if (busy_reg && (bit_reg == 5'd0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= neg;
            mag_reg <= mag;
            den_reg <= den;
            rem_reg <= mag >> SH;
            quo_reg <= '0;
            bit_reg <= 5'd30;
            if (over)
                q_reg <= neg ? 32'sh80000000 : 32'sh7fffffff;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next[nfpi_pkg::MAG_W-1:0];
            quo_reg <= quo_next;
            bit_reg <= bit_reg - 5'd1;
            if (bit_reg == 5'd0)
                q_reg <= neg_reg ? -qv : qv;
        end
    end

    assign done = done_reg;
    assign q    = q_reg;
endmodule

### rtl/nfpi_dp.sv
// Datapath: orbit registers, one shared 33x33 multiplier, an accumulator and
// the divider. Depends on nfpi_pkg and nfpi_div.
module nfpi_dp #(
    parameter int FRACTION_BITS = 26
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  nfpi_pkg::op_t                   op,
    input  nfpi_pkg::pixel_t                pixel,
    input  nfpi_pkg::cfg_t                  cfg,
    input  logic [4:0]                      p_eff,
    output nfpi_pkg::dp_stat_t              stat,
    output logic signed [nfpi_pkg::Q_W-1:0] z_real,
    output logic signed [nfpi_pkg::Q_W-1:0] z_imag
);
    localparam int AW = nfpi_pkg::ACC_W;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;

    logic signed [31:0] zr_reg, zi_reg, cr_reg, ci_reg, wr_reg, wi_reg;
    logic signed [31:0] tr_reg, ti_reg, nr_reg, ni_reg, dr_reg, di_reg;
    logic signed [31:0] qr_reg, qi_reg, xr_reg, xi_reg;
    logic [nfpi_pkg::MAG_W-1:0]        den_reg;
    logic signed [AW-1:0]              acc_reg;
    logic signed [nfpi_pkg::PROD_W-1:0] prod_reg;

    logic signed [nfpi_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic                               mul_en;
    logic signed [nfpi_pkg::PROD_W-1:0] prod_full;
    logic signed [nfpi_pkg::PROD_W-1:0] prod_sh;
    logic signed [AW-1:0]               acc_sh, acc_raw;
    logic signed [31:0]                 acc_sat;
    logic signed [31:0]                 step_sub;
    logic signed [AW-1:0]               acc_abs;
    logic signed [32:0]                 xd_r, xd_i;
    logic                               div_start;
    logic                               div_done;
    logic signed [31:0]                 div_q;

    assign xd_r = {xr_reg[31], xr_reg} - {zr_reg[31], zr_reg};
    assign xd_i = {xi_reg[31], xi_reg} - {zi_reg[31], zi_reg};

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (op)
            nfpi_pkg::OP_M_ZRZR: begin mul_a = {zr_reg[31], zr_reg}; mul_b = {zr_reg[31], zr_reg}; end
            nfpi_pkg::OP_M_ZIZI: begin mul_a = {zi_reg[31], zi_reg}; mul_b = {zi_reg[31], zi_reg}; end
            nfpi_pkg::OP_M_WRZR: begin mul_a = {wr_reg[31], wr_reg}; mul_b = {zr_reg[31], zr_reg}; end
            nfpi_pkg::OP_M_WIZI: begin mul_a = {wi_reg[31], wi_reg}; mul_b = {zi_reg[31], zi_reg}; end
            nfpi_pkg::OP_M_WRZI: begin mul_a = {wr_reg[31], wr_reg}; mul_b = {zi_reg[31], zi_reg}; end
            nfpi_pkg::OP_M_WIZR: begin mul_a = {wi_reg[31], wi_reg}; mul_b = {zr_reg[31], zr_reg}; end
            nfpi_pkg::OP_M_PWR:  begin mul_a = {28'd0, p_eff}; mul_b = {wr_reg[31], wr_reg}; end
            nfpi_pkg::OP_M_PWI:  begin mul_a = {28'd0, p_eff}; mul_b = {wi_reg[31], wi_reg}; end
            nfpi_pkg::OP_M_DRDR: begin mul_a = {dr_reg[31], dr_reg}; mul_b = {dr_reg[31], dr_reg}; end
            nfpi_pkg::OP_M_DIDI: begin mul_a = {di_reg[31], di_reg}; mul_b = {di_reg[31], di_reg}; end
            nfpi_pkg::OP_M_NRDR: begin mul_a = {nr_reg[31], nr_reg}; mul_b = {dr_reg[31], dr_reg}; end
            nfpi_pkg::OP_M_NIDI: begin mul_a = {ni_reg[31], ni_reg}; mul_b = {di_reg[31], di_reg}; end
            nfpi_pkg::OP_M_NIDR: begin mul_a = {ni_reg[31], ni_reg}; mul_b = {dr_reg[31], dr_reg}; end
            nfpi_pkg::OP_M_NRDI: begin mul_a = {nr_reg[31], nr_reg}; mul_b = {di_reg[31], di_reg}; end
            nfpi_pkg::OP_M_RQR:
            begin
                mul_a = {cfg.relax_factor[31], cfg.relax_factor};
                mul_b = {qr_reg[31], qr_reg};
            end
            nfpi_pkg::OP_M_RQI:
            begin
                mul_a = {cfg.relax_factor[31], cfg.relax_factor};
                mul_b = {qi_reg[31], qi_reg};
            end
            nfpi_pkg::OP_M_XDR:  begin mul_a = xd_r; mul_b = xd_r; end
            nfpi_pkg::OP_M_XDI:  begin mul_a = xd_i; mul_b = xd_i; end
            default:             mul_en = 1'b0;
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign prod_sh   = prod_reg >>> FRACTION_BITS;
    assign acc_sh    = AW'(prod_sh);
    assign acc_raw   = AW'(prod_reg);
    assign acc_sat   = nfpi_pkg::sat_q(acc_reg);
    assign acc_abs   = acc_reg[AW-1] ? -acc_reg : acc_reg;

    // The relaxed step is subtracted and saturated before c is added.
    always_comb
    begin
        if (op == nfpi_pkg::OP_W_XR)
            step_sub = nfpi_pkg::sat_q(AW'(zr_reg) - AW'(acc_sat));
        else
            step_sub = nfpi_pkg::sat_q(AW'(zi_reg) - AW'(acc_sat));
    end

    assign div_start = (op == nfpi_pkg::OP_DIV_START);

    nfpi_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .neg  (acc_reg[AW-1]),
        .mag  (acc_abs[nfpi_pkg::MAG_W-1:0]),
        .den  (den_reg),
        .done (div_done),
        .q    (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= prod_full;
        case (op)
            nfpi_pkg::OP_LOAD:
            begin
                if (cfg.julia_select)
                begin
                    zr_reg <= pixel.pixel_real;
                    zi_reg <= pixel.pixel_imag;
                    cr_reg <= cfg.seed_real;
                    ci_reg <= cfg.seed_imag;
                end
                else
                begin
                    zr_reg <= ONE;
                    zi_reg <= '0;
                    cr_reg <= pixel.pixel_real;
                    ci_reg <= pixel.pixel_imag;
                end
            end
            nfpi_pkg::OP_A_LDS:    acc_reg <= acc_sh;
            nfpi_pkg::OP_A_ADDS:   acc_reg <= acc_reg + acc_sh;
            nfpi_pkg::OP_A_SUBS:   acc_reg <= acc_reg - acc_sh;
            nfpi_pkg::OP_A_LDR:    acc_reg <= acc_raw;
            nfpi_pkg::OP_A_ADDR:   acc_reg <= acc_reg + acc_raw;
            nfpi_pkg::OP_A_SUBR:   acc_reg <= acc_reg - acc_raw;
            nfpi_pkg::OP_W_COPYZ:
            begin
                wr_reg <= zr_reg;
                wi_reg <= zi_reg;
            end
            nfpi_pkg::OP_W_TR:     tr_reg <= acc_sat;
            nfpi_pkg::OP_W_TI:     ti_reg <= acc_sat;
            nfpi_pkg::OP_W_T2W:
            begin
                wr_reg <= tr_reg;
                wi_reg <= ti_reg;
            end
            nfpi_pkg::OP_W_T2N:
            begin
                nr_reg <= nfpi_pkg::sat_q(AW'(tr_reg) - AW'(ONE));
                ni_reg <= ti_reg;
            end
            nfpi_pkg::OP_W_DR:     dr_reg <= acc_sat;
            nfpi_pkg::OP_W_DI:     di_reg <= acc_sat;
            nfpi_pkg::OP_W_DEN:    den_reg <= acc_reg[nfpi_pkg::MAG_W-1:0];
            nfpi_pkg::OP_W_QR:     qr_reg <= div_q;
            nfpi_pkg::OP_W_QI:     qi_reg <= div_q;
            nfpi_pkg::OP_W_XR:     xr_reg <= nfpi_pkg::sat_q(AW'(step_sub) + AW'(cr_reg));
            nfpi_pkg::OP_W_XI:     xi_reg <= nfpi_pkg::sat_q(AW'(step_sub) + AW'(ci_reg));
            nfpi_pkg::OP_W_COMMIT:
            begin
                zr_reg <= xr_reg;
                zi_reg <= xi_reg;
            end
            default: ;
        endcase
    end

    assign stat.esc      = acc_reg > AW'($signed({1'b0, cfg.escape_radius_sq}));
    assign stat.conv     = acc_reg < AW'($signed({1'b0, cfg.tolerance_sq}));
    assign stat.dz       = (dr_reg == '0) && (di_reg == '0);
    assign stat.div_done = div_done;

    assign z_real = zr_reg;
    assign z_imag = zi_reg;
endmodule

### rtl/nfpi_ctrl.sv
// Controller: microcoded sequencer for one Newton iteration, iteration count
// and the input and result handshakes. Depends on nfpi_pkg.
module nfpi_ctrl #(
    parameter int ITERATION_CAP = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pixel_valid,
    output logic                                pixel_ready,
    input  logic                                out_full,
    input  logic [nfpi_pkg::ITER_W-1:0]         limit_cfg,
    input  logic [4:0]                          p_eff,
    input  nfpi_pkg::dp_stat_t                  stat,
    output nfpi_pkg::ctrl_cmd_t                 cmd
);
    localparam int ITW = $clog2(ITERATION_CAP + 1);
    localparam int LW  = (ITW > nfpi_pkg::ITER_W) ? ITW : nfpi_pkg::ITER_W;
    localparam logic [5:0] PC_POWCHK = 6'd6;
    localparam logic [5:0] PC_T2W    = 6'd17;
    localparam logic [5:0] PC_T2N    = 6'd18;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_RUN, S_DIVW, S_FIN} state_t;
    typedef enum logic [3:0] {
        F_NEXT, F_ESC, F_POWINIT, F_POWCHK, F_CEND, F_JMP, F_DZ, F_DIV, F_TOL
    } flow_t;
    typedef struct packed {
        nfpi_pkg::op_t op;
        flow_t         flow;
    } uc_t;

    // One iteration of the relaxed Newton map as a fixed micro-program.
    function automatic uc_t ucode(input logic [5:0] pc);
        uc_t u;
        u.flow = F_NEXT;
        case (pc)
            6'd0:  u.op = nfpi_pkg::OP_M_ZRZR;
            6'd1:  u.op = nfpi_pkg::OP_A_LDS;
            6'd2:  u.op = nfpi_pkg::OP_M_ZIZI;
            6'd3:  u.op = nfpi_pkg::OP_A_ADDS;
            6'd4:  begin u.op = nfpi_pkg::OP_NOP;     u.flow = F_ESC;     end
            6'd5:  begin u.op = nfpi_pkg::OP_W_COPYZ; u.flow = F_POWINIT; end
            6'd6:  begin u.op = nfpi_pkg::OP_NOP;     u.flow = F_POWCHK;  end
            6'd7:  u.op = nfpi_pkg::OP_M_WRZR;
            6'd8:  u.op = nfpi_pkg::OP_A_LDS;
            6'd9:  u.op = nfpi_pkg::OP_M_WIZI;
            6'd10: u.op = nfpi_pkg::OP_A_SUBS;
            6'd11: u.op = nfpi_pkg::OP_W_TR;
            6'd12: u.op = nfpi_pkg::OP_M_WRZI;
            6'd13: u.op = nfpi_pkg::OP_A_LDS;
            6'd14: u.op = nfpi_pkg::OP_M_WIZR;
            6'd15: u.op = nfpi_pkg::OP_A_ADDS;
            6'd16: begin u.op = nfpi_pkg::OP_W_TI;    u.flow = F_CEND;    end
            6'd17: begin u.op = nfpi_pkg::OP_W_T2W;   u.flow = F_JMP;     end
            6'd18: u.op = nfpi_pkg::OP_W_T2N;
            6'd19: u.op = nfpi_pkg::OP_M_PWR;
            6'd20: u.op = nfpi_pkg::OP_A_LDR;
            6'd21: u.op = nfpi_pkg::OP_W_DR;
            6'd22: u.op = nfpi_pkg::OP_M_PWI;
            6'd23: u.op = nfpi_pkg::OP_A_LDR;
            6'd24: u.op = nfpi_pkg::OP_W_DI;
            6'd25: begin u.op = nfpi_pkg::OP_NOP;     u.flow = F_DZ;      end
            6'd26: u.op = nfpi_pkg::OP_M_DRDR;
            6'd27: u.op = nfpi_pkg::OP_A_LDR;
            6'd28: u.op = nfpi_pkg::OP_M_DIDI;
            6'd29: u.op = nfpi_pkg::OP_A_ADDR;
            6'd30: u.op = nfpi_pkg::OP_W_DEN;
            6'd31: u.op = nfpi_pkg::OP_M_NRDR;
            6'd32: u.op = nfpi_pkg::OP_A_LDR;
            6'd33: u.op = nfpi_pkg::OP_M_NIDI;
            6'd34: u.op = nfpi_pkg::OP_A_ADDR;
            6'd35: begin u.op = nfpi_pkg::OP_DIV_START; u.flow = F_DIV;   end
            6'd36: u.op = nfpi_pkg::OP_W_QR;
            6'd37: u.op = nfpi_pkg::OP_M_NIDR;
            6'd38: u.op = nfpi_pkg::OP_A_LDR;
            6'd39: u.op = nfpi_pkg::OP_M_NRDI;
            6'd40: u.op = nfpi_pkg::OP_A_SUBR;
            6'd41: begin u.op = nfpi_pkg::OP_DIV_START; u.flow = F_DIV;   end
            6'd42: u.op = nfpi_pkg::OP_W_QI;
            6'd43: u.op = nfpi_pkg::OP_M_RQR;
            6'd44: u.op = nfpi_pkg::OP_A_LDS;
            6'd45: u.op = nfpi_pkg::OP_W_XR;
            6'd46: u.op = nfpi_pkg::OP_M_RQI;
            6'd47: u.op = nfpi_pkg::OP_A_LDS;
            6'd48: u.op = nfpi_pkg::OP_W_XI;
            6'd49: u.op = nfpi_pkg::OP_M_XDR;
            6'd50: u.op = nfpi_pkg::OP_A_LDS;
            6'd51: u.op = nfpi_pkg::OP_M_XDI;
            6'd52: u.op = nfpi_pkg::OP_A_ADDS;
            6'd53: begin u.op = nfpi_pkg::OP_W_COMMIT; u.flow = F_TOL;    end
            default: u.op = nfpi_pkg::OP_NOP;
        endcase
        return u;
    endfunction

    state_t      state_reg;
    logic [5:0]  pc_reg;
    logic [3:0]  cnt_reg;
    logic        npath_reg;
    logic [1:0]  status_reg;
    logic [LW-1:0] iter_reg;

    logic [LW-1:0] lim_ext;
    logic [LW-1:0] lim_eff;
    uc_t           uc;

    assign lim_ext = LW'(limit_cfg);
    assign lim_eff = (lim_ext > LW'(ITERATION_CAP)) ? LW'(ITERATION_CAP) : lim_ext;
    assign uc      = ucode(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pc_reg     <= '0;
            cnt_reg    <= '0;
            npath_reg  <= 1'b0;
            status_reg <= nfpi_pkg::STAT_UNRESOLVED;
            iter_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pixel_valid)
                    begin
                        iter_reg  <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    pc_reg <= '0;
                    if (iter_reg == lim_eff)
                    begin
                        status_reg <= nfpi_pkg::STAT_UNRESOLVED;
                        state_reg  <= S_FIN;
                    end
                    else
                        state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    pc_reg <= pc_reg + 6'd1;
                    unique case (uc.flow)
                        F_ESC:
                        begin
                            if (stat.esc)
                            begin
                                status_reg <= nfpi_pkg::STAT_ESCAPED;
                                state_reg  <= S_FIN;
                            end
                        end
                        F_POWINIT: cnt_reg <= 4'(p_eff - 5'd2);
                        F_POWCHK:
                        begin
                            npath_reg <= (cnt_reg == 4'd0);
                            if (cnt_reg != 4'd0)
                                cnt_reg <= cnt_reg - 4'd1;
                        end
                        F_CEND:    pc_reg <= npath_reg ? PC_T2N : PC_T2W;
                        F_JMP:     pc_reg <= PC_POWCHK;
                        F_DZ:
                        begin
                            if (stat.dz)
                            begin
                                status_reg <= nfpi_pkg::STAT_UNRESOLVED;
                                state_reg  <= S_FIN;
                            end
                        end
                        F_DIV:     state_reg <= S_DIVW;
                        F_TOL:
                        begin
                            if (stat.conv)
                            begin
                                status_reg <= nfpi_pkg::STAT_CONVERGED;
                                state_reg  <= S_FIN;
                            end
                            else
                            begin
                                iter_reg  <= iter_reg + LW'(1);
                                state_reg <= S_CHECK;
                            end
                        end
                        default: ;
                    endcase
                end
                S_DIVW:
                begin
                    if (stat.div_done)
                        state_reg <= S_RUN;
                end
                S_FIN:
                begin
                    if (!out_full)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign pixel_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd.op         = nfpi_pkg::OP_NOP;
        cmd.out_load   = (state_reg == S_FIN) && !out_full;
        cmd.status     = status_reg;
        cmd.iterations = iter_reg[nfpi_pkg::ITER_W-1:0];
        if ((state_reg == S_IDLE) && pixel_valid)
            cmd.op = nfpi_pkg::OP_LOAD;
        else if (state_reg == S_RUN)
            cmd.op = uc.op;
    end
endmodule

### rtl/nova_fractal_pixel_iterator.sv
// Top level of the Nova fractal pixel iterator: configuration registers,
// result register and the controller/datapath pair. Depends on nfpi_pkg,
// nfpi_ctrl, nfpi_dp and nfpi_div.
//
// Each pixel beat runs the relaxed Newton map z <- z - R*(z^p-1)/(p*z^(p-1)) + c
// in signed Q6.26 with saturation, one pixel at a time. A single shared 33x33
// multiplier does every product and a restoring divider makes one quotient bit
// per cycle. One full iteration is a limit check, then the micro-program of
// multiply, accumulate and write-back steps with two divide waits; a divide
// whose quotient saturates skips its bit loop, and an iteration that escapes
// or meets a zero derivative ends early. The pixel port is ready only while no
// pixel is in work; the finished result sits in an output register, so the
// next pixel is taken while the previous result waits for its consumer. The
// status is 0 for escaped, 1 for converged and 2 for unresolved (iteration
// limit or zero derivative), and the result carries the last z. Configuration
// is to be written over the APB port only while the block is idle; the block
// itself does not enforce it. All eight registers read back.
module nova_fractal_pixel_iterator #(
    parameter int ITERATION_CAP  = 4096,
    parameter int MAX_EXPONENT   = 8,
    parameter int FRACTION_BITS  = 26
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_ready,
    input  nfpi_pkg::pixel_t  pixel,
    output logic              result_valid,
    input  logic              result_ready,
    output nfpi_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic                  julia_reg;
    logic signed [31:0]    seed_real_reg;
    logic signed [31:0]    seed_imag_reg;
    logic [3:0]            exponent_reg;
    logic [12:0]           limit_reg;
    logic [31:0]           escape_reg;
    logic signed [31:0]    relax_reg;
    logic [31:0]           tol_reg;

    logic                  result_valid_reg;
    nfpi_pkg::result_t     result_reg;

    logic                  wr_en;
    logic [2:0]            reg_idx;
    logic [4:0]            p_eff;
    nfpi_pkg::cfg_t        cfg;
    nfpi_pkg::dp_stat_t    stat;
    nfpi_pkg::ctrl_cmd_t   cmd;
    logic signed [31:0]    z_real;
    logic signed [31:0]    z_imag;
    logic                  out_full;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes land on the access phase of an APB write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            julia_reg     <= 1'b0;
            seed_real_reg <= '0;
            seed_imag_reg <= '0;
            exponent_reg  <= 4'd3;
            limit_reg     <= 13'd256;
            escape_reg    <= 32'h4000_0000;
            relax_reg     <= 32'sh0400_0000;
            tol_reg       <= 32'd67;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                nfpi_pkg::REG_JULIA:    julia_reg     <= pwdata[0];
                nfpi_pkg::REG_SEED_RE:  seed_real_reg <= pwdata;
                nfpi_pkg::REG_SEED_IM:  seed_imag_reg <= pwdata;
                nfpi_pkg::REG_EXPONENT: exponent_reg  <= pwdata[3:0];
                nfpi_pkg::REG_LIMIT:    limit_reg     <= pwdata[12:0];
                nfpi_pkg::REG_ESCAPE:   escape_reg    <= pwdata;
                nfpi_pkg::REG_RELAX:    relax_reg     <= pwdata;
                nfpi_pkg::REG_TOL:      tol_reg       <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            nfpi_pkg::REG_JULIA:    prdata = {31'd0, julia_reg};
            nfpi_pkg::REG_SEED_RE:  prdata = seed_real_reg;
            nfpi_pkg::REG_SEED_IM:  prdata = seed_imag_reg;
            nfpi_pkg::REG_EXPONENT: prdata = {28'd0, exponent_reg};
            nfpi_pkg::REG_LIMIT:    prdata = {19'd0, limit_reg};
            nfpi_pkg::REG_ESCAPE:   prdata = escape_reg;
            nfpi_pkg::REG_RELAX:    prdata = relax_reg;
            nfpi_pkg::REG_TOL:      prdata = tol_reg;
            default:                prdata = '0;
        endcase
    end

    assign cfg.julia_select     = julia_reg;
    assign cfg.seed_real        = seed_real_reg;
    assign cfg.seed_imag        = seed_imag_reg;
    assign cfg.escape_radius_sq = escape_reg;
    assign cfg.relax_factor     = relax_reg;
    assign cfg.tolerance_sq     = tol_reg;

    assign p_eff = nfpi_pkg::clamp_exponent(exponent_reg, 5'(MAX_EXPONENT));

    // The controller may finish only when the result register is free or
    // is being emptied in the same cycle.
    assign out_full = result_valid_reg && !result_ready;

    nfpi_ctrl #(
        .ITERATION_CAP(ITERATION_CAP)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_valid(pixel_valid),
        .pixel_ready(pixel_ready),
        .out_full   (out_full),
        .limit_cfg  (limit_reg),
        .p_eff      (p_eff),
        .stat       (stat),
        .cmd        (cmd)
    );

    nfpi_dp #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (cmd.op),
        .pixel (pixel),
        .cfg   (cfg),
        .p_eff (p_eff),
        .stat  (stat),
        .z_real(z_real),
        .z_imag(z_imag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.out_load)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.status     <= cmd.status;
            result_reg.iterations <= cmd.iterations;
            result_reg.final_real <= z_real;
            result_reg.final_imag <= z_imag;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
endmodule

### rtl/nfpi_chk.sv
// Port-level checker for the Nova fractal pixel iterator, bound to the top.
// Depends on nfpi_pkg and nova_fractal_pixel_iterator.
module nfpi_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              pixel_valid,
    input logic              pixel_ready,
    input logic              result_valid,
    input logic              result_ready,
    input nfpi_pkg::result_t result,
    input logic              pready
);
    // A stalled result beat must hold.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // Only three status codes exist.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == nfpi_pkg::STAT_ESCAPED) ||
                         (result.status == nfpi_pkg::STAT_CONVERGED) ||
                         (result.status == nfpi_pkg::STAT_UNRESOLVED))
        else $error("illegal status code");

    // Taking a pixel starts work, so the port closes on the next cycle.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> !pixel_ready)
        else $error("second pixel taken while one is in work");

    // Escape and convergence stop inside the limit, never beyond 4095.
    a_early_stop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != nfpi_pkg::STAT_UNRESOLVED)
        |-> result.iterations < 13'd4096)
        else $error("early stop beyond the iteration range");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("configuration port stalled");
endmodule

bind nova_fractal_pixel_iterator nfpi_chk u_nfpi_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .pready      (pready)
);
